/* design/clp_pkg.sv */
`timescale 1ns / 1ps

package clp_pkg;

    localparam int MAX_DIGITS   = 5;
    localparam int MAX_COMMANDS = 8;

    localparam int CHAR_W    = 8;
    localparam int INDEX_W   = 3;
    localparam int VALUE_W   = 16;
    localparam int COUNT_W   = 4;
    localparam int LETTERS_W = 64;
    localparam int DIGITS_W  = $clog2(MAX_DIGITS + 1);
    localparam int DIGIT_W   = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    typedef enum logic {
        CFG_COMMAND_COUNT   = 1'b0,
        CFG_COMMAND_LETTERS = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        TOK_OPEN  = 2'd0,
        TOK_MINUS = 2'd1,
        TOK_DIGIT = 2'd2,
        TOK_CLOSE = 2'd3
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind            kind;
        logic [INDEX_W-1:0]   index;
        logic [CHAR_W-1:0]    data;
    } t_token;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_status;

endpackage

/* design/clp_front.sv */
`timescale 1ns / 1ps

module clp_front
    import clp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [CHAR_W-1:0]    i_in_char,
    input  logic [COUNT_W-1:0]   i_command_count,
    input  logic [LETTERS_W-1:0] i_command_letters,
    output logic                 o_push,
    output t_token               o_token
);

    logic                r_open;
    logic                n_open;
    logic [COUNT_W-1:0]  active_count;
    logic                match_found;
    logic [INDEX_W-1:0]  match_index;
    logic [CHAR_W-1:0]   digit_offset;

    always_comb begin
        if (i_command_count > COUNT_W'(MAX_COMMANDS)) begin
            active_count = COUNT_W'(MAX_COMMANDS);
        end else begin
            active_count = i_command_count;
        end
    end

    always_comb begin
        match_found = 1'b0;
        match_index = '0;
        for (int i = MAX_COMMANDS - 1; i >= 0; i--) begin
            if ((COUNT_W'(i) < active_count) &&
                (i_command_letters[CHAR_W*i +: CHAR_W] == i_in_char)) begin
                match_found = 1'b1;
                match_index = INDEX_W'(i);
            end
        end
    end

    assign digit_offset = i_in_char - CHAR_ZERO;

    always_comb begin
        n_open        = r_open;
        o_push        = 1'b0;
        o_token.kind  = TOK_OPEN;
        o_token.index = match_index;
        o_token.data  = i_in_char;
        if (!r_open) begin
            if (i_accept && match_found) begin
                o_push = 1'b1;
                n_open = 1'b1;
            end
        end else begin
            priority if (i_in_char == CHAR_MINUS) begin
                o_token.kind = TOK_MINUS;
                o_push       = i_accept;
            end else if ((i_in_char >= CHAR_ZERO) && (i_in_char <= CHAR_NINE)) begin
                o_token.kind = TOK_DIGIT;
                o_token.data = digit_offset;
                o_push       = i_accept;
            end else if ((i_in_char == CHAR_CR) || (i_in_char == CHAR_LF)) begin
                o_token.kind = TOK_CLOSE;
                o_push       = i_accept;
                if (i_accept) begin
                    n_open = 1'b0;
                end
            end else begin
                o_push = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= n_open;
        end
    end

endmodule

/* design/clp_fifo.sv */
`timescale 1ns / 1ps

module clp_fifo
    import clp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_token       i_token,
    input  logic         i_pop,
    output t_token       o_token,
    output t_fifo_status o_status
);

    t_token                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_token        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/clp_back.sv */
`timescale 1ns / 1ps

module clp_back
    import clp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tok_valid,
    input  t_token                     i_token,
    output logic                       o_pop,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [INDEX_W-1:0]         o_command_index,
    output logic [CHAR_W-1:0]          o_command_char,
    output logic signed [VALUE_W-1:0]  o_value
);

    logic [VALUE_W-1:0]  r_acc;
    logic [DIGITS_W-1:0] r_digits;
    logic                r_minus;
    logic [INDEX_W-1:0]  r_index;
    logic [CHAR_W-1:0]   r_letter;
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_index;
    logic [CHAR_W-1:0]   r_out_char;
    logic [VALUE_W-1:0]  r_out_value;
    logic                out_free;
    logic                is_close;
    logic [VALUE_W-1:0]  acc_times_ten;
    logic [VALUE_W-1:0]  close_value;

    assign out_free = !r_out_valid || !i_stall;
    assign is_close = (i_token.kind == TOK_CLOSE);
    assign o_pop    = i_tok_valid && (!is_close || out_free);

    assign acc_times_ten = {r_acc[VALUE_W-4:0], 3'b000} + {r_acc[VALUE_W-2:0], 1'b0}
                         + VALUE_W'(i_token.data[DIGIT_W-1:0]);
    assign close_value   = r_minus ? (VALUE_W'(0) - r_acc) : r_acc;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            unique case (i_token.kind)
                TOK_OPEN: begin
                    r_acc    <= '0;
                    r_digits <= '0;
                    r_minus  <= 1'b0;
                    r_index  <= i_token.index;
                    r_letter <= i_token.data;
                end
                TOK_MINUS: begin
                    r_minus <= 1'b1;
                end
                TOK_DIGIT: begin
                    if (r_digits < DIGITS_W'(MAX_DIGITS)) begin
                        r_acc    <= acc_times_ten;
                        r_digits <= r_digits + 1'b1;
                    end
                end
                TOK_CLOSE: begin
                    r_out_index <= r_index;
                    r_out_char  <= r_letter;
                    r_out_value <= close_value;
                end
                default: begin
                    r_minus <= r_minus;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && is_close) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_command_index = r_out_index;
    assign o_command_char  = r_out_char;
    assign o_value         = r_out_value;

endmodule

/* design/command_letter_number_parser_unit.sv */
`timescale 1ns / 1ps

// The unit parses a stream of received characters into letter commands with a
// signed decimal argument. Characters enter on i_in_char with i_valid, and a
// beat is taken at an edge where i_valid is high and o_stall is low. Results
// leave on o_command_index, o_command_char and o_value with o_valid, and a
// beat is taken at an edge where o_valid is high and i_stall is low.
// The front stage accepts one character per cycle while the queue is not full
// and classifies it; a four-entry token queue feeds the back stage, which
// accumulates the value and holds the result in an output register. A closing
// CR or LF is queued and then registered there, raising o_valid. Throughput
// is one character per cycle as long as results are taken; while the receiver
// stalls, tokens other than a close keep draining and o_stall rises only
// when the queue is full. Configuration writes on i_cfg_valid are always
// ready: index 0 sets the command count, index 1 the packed letter table.
// They are meant to be issued only while the unit is idle. Synchronous reset
// clears the configuration, closes any open command, empties the queue and
// drops o_valid.

module command_letter_number_parser_unit
    import clp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [CHAR_W-1:0]          i_in_char,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [INDEX_W-1:0]         o_command_index,
    output logic [CHAR_W-1:0]          o_command_char,
    output logic signed [VALUE_W-1:0]  o_value,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  t_cfg_index                 i_cfg_index,
    input  logic [LETTERS_W-1:0]       i_cfg_data
);

    logic [COUNT_W-1:0]   r_command_count;
    logic [LETTERS_W-1:0] r_command_letters;
    logic                 in_accept;
    logic                 push;
    t_token               push_token;
    t_token               head_token;
    t_fifo_status         fifo_status;
    logic                 pop;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = fifo_status.full;
    assign in_accept   = i_valid && !fifo_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command_count   <= '0;
            r_command_letters <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COMMAND_COUNT:   r_command_count   <= i_cfg_data[COUNT_W-1:0];
                CFG_COMMAND_LETTERS: r_command_letters <= i_cfg_data;
                default:             r_command_count   <= r_command_count;
            endcase
        end
    end

    clp_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_in_char         (i_in_char),
        .i_command_count   (r_command_count),
        .i_command_letters (r_command_letters),
        .o_push            (push),
        .o_token           (push_token)
    );

    clp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_token  (push_token),
        .i_pop    (pop),
        .o_token  (head_token),
        .o_status (fifo_status)
    );

    clp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tok_valid     (!fifo_status.empty),
        .i_token         (head_token),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_command_index (o_command_index),
        .o_command_char  (o_command_char),
        .o_value         (o_value)
    );

endmodule

/* design/clp_checker.sv */
`timescale 1ns / 1ps

module clp_checker
    import clp_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [INDEX_W-1:0]         o_command_index,
    input logic [CHAR_W-1:0]          o_command_char,
    input logic signed [VALUE_W-1:0]  o_value
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_command_index) && $stable(o_command_char)
                               && $stable(o_value))
        else $error("result payload changed while stalled");

    // Reset leaves no result pending.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Reset empties the token queue, so input is accepted right away.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

endmodule

bind command_letter_number_parser_unit clp_checker u_clp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_command_index (o_command_index),
    .o_command_char  (o_command_char),
    .o_value         (o_value)
);

/* dv/command_letter_number_parser_unit_tb.sv */
`timescale 1ns / 1ps

module command_letter_number_parser_unit_tb;
    import clp_pkg::*;

    typedef struct {
        logic [INDEX_W-1:0]        index;
        logic [CHAR_W-1:0]         letter;
        logic signed [VALUE_W-1:0] value;
    } t_cmd_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [CHAR_W-1:0]         i_in_char = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [INDEX_W-1:0]        o_command_index;
    logic [CHAR_W-1:0]         o_command_char;
    logic signed [VALUE_W-1:0] o_value;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    t_cfg_index                i_cfg_index = CFG_COMMAND_COUNT;
    logic [LETTERS_W-1:0]      i_cfg_data = '0;

    logic [CHAR_W-1:0] char_q[$];
    t_cmd_result       closed_commands[$];
    t_cmd_result       head;
    logic              calm = 1'b0;
    int                n_pushed = 0;
    int                n_chars = 0;
    int                n_commands = 0;
    int                n_writes = 0;
    int                n_errors = 0;

    // Shadow of the parser, updated on every accepted beat.
    logic [COUNT_W-1:0]   reg_count;
    logic [LETTERS_W-1:0] reg_letters;
    logic                 cmd_open;
    logic [VALUE_W-1:0]   acc_value;
    int                   digit_count;
    logic                 minus_flag;
    logic [INDEX_W-1:0]   open_idx;
    logic [CHAR_W-1:0]    open_chr;

    // Table as last written by the stimulus side, used to pick letters.
    logic [COUNT_W-1:0]   gen_count = '0;
    logic [LETTERS_W-1:0] gen_letters = '0;

    command_letter_number_parser_unit u_top (.*);

    always #1 i_clk = ~i_clk;

    task automatic parse_char(input logic [CHAR_W-1:0] c);
        int          limit;
        logic        found;
        t_cmd_result closing;
        if (!cmd_open) begin
            limit = (reg_count > MAX_COMMANDS) ? MAX_COMMANDS : int'(reg_count);
            found = 1'b0;
            for (int k = 0; k < MAX_COMMANDS; k++) begin
                if (!found && k < limit && reg_letters[8*k +: 8] == c) begin
                    found = 1'b1;
                    cmd_open = 1'b1;
                    acc_value = '0;
                    digit_count = 0;
                    minus_flag = 1'b0;
                    open_idx = INDEX_W'(k);
                    open_chr = c;
                end
            end
        end else if (c == CHAR_MINUS) begin
            minus_flag = 1'b1;
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (digit_count < MAX_DIGITS) begin
                acc_value = VALUE_W'(acc_value * 10 + (c - CHAR_ZERO));
                digit_count++;
            end
        end else if (c == CHAR_LF || c == CHAR_CR) begin
            closing.index = open_idx;
            closing.letter = open_chr;
            closing.value = minus_flag ? (~acc_value + 1'b1) : acc_value;
            closed_commands.push_back(closing);
            cmd_open = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_count = '0;
            reg_letters = '0;
            cmd_open = 1'b0;
            acc_value = '0;
            digit_count = 0;
            minus_flag = 1'b0;
            open_idx = '0;
            open_chr = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                n_writes++;
                case (i_cfg_index)
                    CFG_COMMAND_COUNT:   reg_count = i_cfg_data[COUNT_W-1:0];
                    CFG_COMMAND_LETTERS: reg_letters = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                n_chars++;
                parse_char(i_in_char);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_in_char <= '0;
        end else if (!i_valid || !o_stall) begin
            if (char_q.size() > 0 && (calm || $urandom_range(0, 99) >= 12)) begin
                i_valid <= 1'b1;
                i_in_char <= char_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !calm && ($urandom_range(0, 99) < 12);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (closed_commands.size() == 0) begin
                $error("result with nothing pending: index %0d char 0x%02h value %0d",
                       o_command_index, o_command_char, o_value);
                n_errors++;
            end else begin
                head = closed_commands.pop_front();
                n_commands++;
                if (o_command_index !== head.index) begin
                    $error("command_index mismatch: expected %0d, actual %0d",
                           head.index, o_command_index);
                    n_errors++;
                end
                if (o_command_char !== head.letter) begin
                    $error("command_char mismatch: expected 0x%02h, actual 0x%02h",
                           head.letter, o_command_char);
                    n_errors++;
                end
                if (o_value !== head.value) begin
                    $error("value mismatch: expected %0d, actual %0d", head.value, o_value);
                    n_errors++;
                end
            end
        end
    end

    task automatic push_char(input logic [CHAR_W-1:0] c);
        char_q.push_back(c);
        n_pushed++;
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            push_char(s[k]);
        end
    endtask

    function automatic int active_letters();
        return (gen_count > MAX_COMMANDS) ? MAX_COMMANDS : int'(gen_count);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_letter();
        return gen_letters[8*$urandom_range(0, active_letters() - 1) +: 8];
    endfunction

    function automatic logic [CHAR_W-1:0] rand_digit(input logic nines);
        return nines ? CHAR_NINE : CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    task automatic push_command();
        int   ndig;
        int   minus_at;
        logic nines;
        push_char(pick_letter());
        ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 5);
        minus_at = $urandom_range(0, ndig + 3);
        nines = ($urandom_range(0, 4) == 0);
        for (int k = 0; k <= ndig; k++) begin
            if (k == minus_at) begin
                push_char(CHAR_MINUS);
            end
            if ($urandom_range(0, 9) == 0) begin
                push_char(CHAR_W'($urandom_range(0, 255)));
            end
            if (k < ndig) begin
                push_char(rand_digit(nines));
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            push_char(CHAR_MINUS);
        end
        push_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    endtask

    task automatic gen_phase(input int n);
        int start;
        start = n_pushed;
        while (n_pushed - start < n) begin
            if (active_letters() > 0 && $urandom_range(0, 99) < 80) begin
                push_command();
            end else begin
                push_char(CHAR_W'($urandom_range(0, 255)));
            end
        end
        // Sometimes leave a command open across the next table update.
        if (active_letters() > 0 && $urandom_range(0, 2) == 0) begin
            push_char(pick_letter());
            push_char(rand_digit(1'b0));
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (char_q.size() != 0 || i_valid || closed_commands.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [LETTERS_W-1:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [COUNT_W-1:0] cnt, input logic [LETTERS_W-1:0] tbl);
        write_reg(CFG_COMMAND_COUNT, LETTERS_W'(cnt));
        write_reg(CFG_COMMAND_LETTERS, tbl);
        gen_count = cnt;
        gen_letters = tbl;
        @(negedge i_clk);
    endtask

    function automatic logic [LETTERS_W-1:0] printable_table();
        logic [LETTERS_W-1:0] t;
        for (int k = 0; k < MAX_COMMANDS; k++) begin
            t[8*k +: 8] = "A" + CHAR_W'($urandom_range(0, 57));
        end
        return t;
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // With the reset table nothing can open a command.
        push_text("A5");
        push_char(CHAR_LF);
        push_char(8'h00);
        settle();

        configure(4'hF, {8'hFF, "hgfeMM", 8'h00});
        push_char(CHAR_CR);
        push_char(8'h00);
        push_text("-999999");
        push_char(CHAR_LF);
        push_char("M");
        push_char(CHAR_CR);
        push_char(8'hFF);
        push_text("32-768");
        push_char(8'h80);
        push_char(CHAR_MINUS);
        push_char(CHAR_CR);
        push_text("M42");
        settle();

        // The open command keeps the letter and index it was opened with.
        configure(4'd8, {"HGFEDCBA"});
        push_char("7");
        push_char(CHAR_LF);
        calm = 1'b1;
        gen_phase(130);
        settle();
        calm = 1'b0;
        gen_phase(120);
        settle();

        configure(4'd1, {$urandom, $urandom});
        gen_phase(120);
        settle();

        configure(4'd3, {LETTERS_W{1'b1}});
        gen_phase(100);
        settle();

        configure(4'd0, '0);
        gen_phase(40);
        settle();

        configure(4'hF, {$urandom, $urandom});
        gen_phase(220);
        settle();

        configure(4'd5, printable_table());
        gen_phase(220);
        settle();

        $display("Checked %0d commands parsed from %0d characters, %0d register writes.",
                 n_commands, n_chars, n_writes);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
